>>> src/ita_pkg.sv
// Shared types, character codes and helpers for the integer-to-ASCII formatter.
// Used by ita_ctrl, ita_dp and the int_to_ascii_dec_hex top level.
// No dependencies.
package ita_pkg;

	// Default width of the integer being formatted.
	localparam int VALUE_BITS_DEF = 32;

	// Format mode codes carried on the command field.
	localparam logic CMD_DEC = 1'b0;
	localparam logic CMD_HEX = 1'b1;

	// ASCII codes used in the formatted text.
	localparam logic [6:0] CHAR_ZERO  = 7'h30;  // '0'
	localparam logic [6:0] CHAR_X     = 7'h78;  // 'x'
	localparam logic [6:0] CHAR_MINUS = 7'h2D;  // '-'
	localparam logic [6:0] CHAR_ALPHA = 7'h37;  // 'A' - 10
	localparam logic [3:0] NIB_TEN    = 4'd10;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;     // capture a new request
		logic convert;  // one binary-to-BCD step of four bits
		logic scan;     // find the leading digit and set up the prefix
		logic emit;     // move the next character into the output register
	} ita_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic conv_done;  // this is the final conversion step
		logic emit_last;  // the character now selected ends the text
		logic out_free;   // the output register can take a character
	} ita_sts_t;

	// Turns one digit (decimal or hex) into its uppercase ASCII code.
	function automatic logic [6:0] digit_char(input logic [3:0] nib);
		logic [6:0] ext;
		ext = {3'b000, nib};
		if (nib < NIB_TEN) begin
			return CHAR_ZERO + ext;
		end else begin
			return CHAR_ALPHA + ext;
		end
	endfunction

endpackage

>>> src/ita_ctrl.sv
// Controller state machine of the integer-to-ASCII formatter.
// Sequences load, conversion, leading-digit scan and character output.
// Depends on ita_pkg.
module ita_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_command,
	input  ita_pkg::ita_sts_t sts,
	output logic              in_stall,
	output ita_pkg::ita_cmd_t cmd
);
	import ita_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONVERT,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t state_q;

	// A new request is taken only while nothing is in progress.
	assign in_stall = (state_q != ST_IDLE);

	// Commands follow directly from the state.
	always_comb begin
		cmd.load    = (state_q == ST_IDLE) && in_valid;
		cmd.convert = (state_q == ST_CONVERT);
		cmd.scan    = (state_q == ST_SCAN);
		cmd.emit    = (state_q == ST_EMIT) && sts.out_free;
	end

	// State register. Hex requests need no conversion and go straight to the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= (in_command == CMD_HEX) ? ST_SCAN : ST_CONVERT;
					end
				end
				ST_CONVERT: begin
					if (sts.conv_done) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (sts.out_free && sts.emit_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> src/ita_dp.sv
// Datapath of the integer-to-ASCII formatter: magnitude, BCD digit buffer,
// leading-digit scan, prefix and digit selection, and the output register.
// Depends on ita_pkg.
module ita_dp #(
	parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [VALUE_BITS-1:0]  value,
	input  logic                   command,
	input  ita_pkg::ita_cmd_t      cmd,
	input  logic                   out_stall,
	output ita_pkg::ita_sts_t      sts,
	output logic                   out_valid,
	output logic [6:0]             character,
	output logic                   last
);
	import ita_pkg::*;

	// Hex digits of the value, and decimal digits of the largest magnitude.
	localparam int NIB   = (VALUE_BITS + 3) / 4;
	localparam int MAG_W = NIB * 4;
	localparam int DEC_N = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int BUF_N = (DEC_N > NIB) ? DEC_N : NIB;
	localparam int BUF_W = BUF_N * 4;
	localparam int IDX_W = $clog2(BUF_N);
	localparam int CNT_W = $clog2(NIB);

	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] magnitude;
	logic                  is_neg;

	logic                  mode_q;
	logic                  neg_q;
	logic [MAG_W-1:0]      mag_q;
	logic [BUF_W-1:0]      buf_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      idx_q;
	logic [1:0]            pre_q;

	logic [BUF_W-1:0]      bcd_next;
	logic [IDX_W-1:0]      top_idx;
	logic [3:0]            cur_nib;
	logic [6:0]            cur_char;

	logic                  out_valid_q;
	logic [6:0]            character_q;
	logic                  last_q;

	// Decimal magnitude; the most negative value wraps to its correct unsigned size.
	assign raw       = value;
	assign is_neg    = raw[VALUE_BITS-1] && (command == CMD_DEC);
	assign magnitude = is_neg ? (~raw + 1'b1) : raw;

	// Four shift-add-3 steps per cycle, magnitude bits taken most significant first.
	always_comb begin
		logic [BUF_W-1:0] b;
		b = buf_q;
		for (int s = 0; s < 4; s++) begin
			for (int d = 0; d < BUF_N; d++) begin
				if (b[d*4 +: 4] >= 4'd5) begin
					b[d*4 +: 4] = b[d*4 +: 4] + 4'd3;
				end
			end
			b = {b[BUF_W-2:0], mag_q[MAG_W-1-s]};
		end
		bcd_next = b;
	end

	// Highest nonzero digit, or the lowest digit when all are zero.
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < BUF_N; i++) begin
			if (buf_q[i*4 +: 4] != 4'd0) begin
				top_idx = IDX_W'(i);
			end
		end
	end

	// Character now due: the prefix first, then digits from the top down.
	assign cur_nib = buf_q[{idx_q, 2'b00} +: 4];
	always_comb begin
		cur_char = digit_char(cur_nib);
		if (pre_q != 2'd0) begin
			if (mode_q == CMD_HEX) begin
				cur_char = (pre_q == 2'd2) ? CHAR_ZERO : CHAR_X;
			end else begin
				cur_char = CHAR_MINUS;
			end
		end
	end

	assign sts.conv_done = (cnt_q == CNT_W'(NIB - 1));
	assign sts.emit_last = (pre_q == 2'd0) && (idx_q == '0);
	assign sts.out_free  = !out_valid_q || !out_stall;

	// Working registers: request capture, conversion, scan and output pointer.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= command;
			neg_q  <= is_neg;
			mag_q  <= MAG_W'(magnitude);
			buf_q  <= (command == CMD_HEX) ? BUF_W'(raw) : '0;
			cnt_q  <= '0;
		end else if (cmd.convert) begin
			mag_q <= {mag_q[MAG_W-5:0], 4'b0000};
			buf_q <= bcd_next;
			cnt_q <= cnt_q + 1'b1;
		end
		if (cmd.scan) begin
			idx_q <= top_idx;
			pre_q <= (mode_q == CMD_HEX) ? 2'd2 : {1'b0, neg_q};
		end else if (cmd.emit) begin
			if (pre_q != 2'd0) begin
				pre_q <= pre_q - 1'b1;
			end else if (idx_q != '0) begin
				idx_q <= idx_q - 1'b1;
			end
		end
	end

	// Output register: holds a character until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			character_q <= cur_char;
			last_q      <= sts.emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign character = character_q;
	assign last      = last_q;

	// The controller never overwrites a character that is still waiting.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || !out_stall))
		else $error("character overwritten while stalled");

	// Hex requests never run through the decimal conversion.
	a_convert_dec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.convert |-> (mode_q == CMD_DEC))
		else $error("conversion step in hex mode");

	// After the scan the pointer sits on a nonzero digit, unless the number is zero.
	a_scan_top: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |=> ((idx_q == '0) || (buf_q[{idx_q, 2'b00} +: 4] != 4'd0)))
		else $error("leading digit scan missed");

endmodule

>>> src/int_to_ascii_dec_hex.sv
// Top level of the integer-to-ASCII formatter.
// Instantiates ita_ctrl and ita_dp; depends on ita_pkg.
//
// Formats one signed integer per request as ASCII text, one character per
// result with the final one flagged by last. With command 0 the text is
// decimal: a '-' for negatives (the most negative value prints its full
// magnitude), then digits with no leading zeros, "0" for zero. With command
// 1 it is "0x" and the uppercase two's-complement nibbles, leading zeros
// dropped, at least one digit. A decimal request is accepted, converted four
// bits per step through the shift-add-3 BCD unit, scanned for its leading
// digit, and then its characters are emitted. A hex request skips the
// conversion. Characters leave one per cycle through the output register
// while out_stall is low; the next request is taken once the last
// character is in that register.
module int_to_ascii_dec_hex #(
	parameter int VALUE_BITS = ita_pkg::VALUE_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] value,
	input  logic                  command,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [6:0]            character,
	output logic                  last
);
	import ita_pkg::*;

	ita_cmd_t cmd;
	ita_sts_t sts;

	// Sequencing of each request.
	ita_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_command (command),
		.sts        (sts),
		.in_stall   (in_stall),
		.cmd        (cmd)
	);

	// Conversion, digit selection and the output register.
	ita_dp #(
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.value      (value),
		.command    (command),
		.cmd        (cmd),
		.out_stall  (out_stall),
		.sts        (sts),
		.out_valid  (out_valid),
		.character  (character),
		.last       (last)
	);

endmodule
